### rtl/ptpa_pkg.sv
// ----------------------------------------------------------------------------
// ptpa_pkg
// Shared widths, request codes and controller states of the page table.
// ----------------------------------------------------------------------------
package ptpa_pkg;

  localparam int OFFSET_BITS = 12;
  localparam int VPAGE_BITS  = 12;
  localparam int FRAME_COUNT = 1024;
  localparam int ADDR_BITS   = 24;
  localparam int FRAME_BITS  = 10;
  localparam int PAGE_COUNT  = 1 << VPAGE_BITS;
  localparam int FIDX_BITS   = $clog2(FRAME_COUNT);

  localparam logic [1:0] FUNC_TRANSLATE = 2'd0;
  localparam logic [1:0] FUNC_MAP       = 2'd1;
  localparam logic [1:0] FUNC_ALLOC     = 2'd2;
  localparam logic [1:0] FUNC_FREE      = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_ARD,
    S_ACK,
    S_MRD,
    S_MCK,
    S_FRD,
    S_FCK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                  valid;
    logic [FRAME_BITS-1:0] frame;
  } pte_t;

endpackage

### rtl/page_table_with_page_allocator.sv
// ----------------------------------------------------------------------------
// page_table_with_page_allocator
// Page table with translate, map, first-fit allocate and free.
// ----------------------------------------------------------------------------
// After reset the block sweeps both tables and holds in_stall high. One
// request is handled at a time. Translate and map read the page table when
// the request is accepted, check the entry in S_LOOK and register the result
// from S_DONE, after which the next request can be taken. Allocate reads and
// checks each scanned page until a free run is found, then each probed frame;
// free reads and clears each released page. Each table memory has a single
// read port. One result word is buffered at the output, so the next request
// is taken while a result waits.
module page_table_with_page_allocator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          func,
  input  logic [ptpa_pkg::ADDR_BITS-1:0]      virt_addr,
  input  logic [ptpa_pkg::FRAME_BITS-1:0]     frame_number,
  input  logic [ptpa_pkg::ADDR_BITS-1:0]      byte_count,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                status,
  output logic [ptpa_pkg::ADDR_BITS-1:0]      result_addr
);

  localparam int AB = ptpa_pkg::ADDR_BITS;
  localparam int VB = ptpa_pkg::VPAGE_BITS;
  localparam int OB = ptpa_pkg::OFFSET_BITS;
  localparam int FB = ptpa_pkg::FIDX_BITS;

  ptpa_pkg::state_t state, state_next;

  // table memories
  ptpa_pkg::pte_t pmem [ptpa_pkg::PAGE_COUNT];
  logic           fmem [ptpa_pkg::FRAME_COUNT];

  logic [VB-1:0]  pr_addr;
  ptpa_pkg::pte_t pr_data;
  logic           pw_en;
  logic [VB-1:0]  pw_addr;
  ptpa_pkg::pte_t pw_data;
  logic [FB-1:0]  fr_addr;
  logic           fr_data;
  logic           fw_en;
  logic [FB-1:0]  fw_addr;
  logic           fw_data;

  always_ff @(posedge clk) begin
    if (pw_en) pmem[pw_addr] <= pw_data;
    pr_data <= pmem[pr_addr];
  end

  always_ff @(posedge clk) begin
    if (fw_en) fmem[fw_addr] <= fw_data;
    fr_data <= fmem[fr_addr];
  end

  // request and walk registers
  logic [1:0]    rq_func;
  logic [AB-1:0] rq_va;
  logic [ptpa_pkg::FRAME_BITS-1:0] rq_frame;
  logic [AB-1:0] rq_count;
  logic [AB:0]   rq_last;
  logic [VB:0]   rq_need;
  logic [VB-1:0] clr_cnt, clr_cnt_next;
  logic [VB-1:0] pg, pg_next;
  logic [VB-1:0] run, run_next;
  logic [VB-1:0] start, start_next;
  logic [VB-1:0] k, k_next;
  logic [FB:0]   f, f_next;
  logic [AB:0]   wa, wa_next;
  logic          res_status, res_status_next;
  logic [AB-1:0] res_addr, res_addr_next;

  logic [AB:0] in_last;
  logic [AB:0] need_sum;
  logic        accept;
  logic [AB:0] wa_step;

  assign in_last  = {1'b0, virt_addr} + {1'b0, byte_count} - 1'b1;
  assign accept   = in_valid && !in_stall;
  assign need_sum = {1'b0, byte_count} + (AB+1)'((1 << OB) - 1);
  assign wa_step  = wa + (AB+1)'(1 << OB);

  always_ff @(posedge clk) begin
    if (accept) begin
      rq_func  <= func;
      rq_va    <= virt_addr;
      rq_frame <= frame_number;
      rq_count <= byte_count;
      rq_last  <= in_last;
      rq_need  <= need_sum[AB:OB];
    end
    clr_cnt    <= clr_cnt_next;
    pg         <= pg_next;
    run        <= run_next;
    start      <= start_next;
    k          <= k_next;
    f          <= f_next;
    wa         <= wa_next;
    res_status <= res_status_next;
    res_addr   <= res_addr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ptpa_pkg::S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ptpa_pkg::S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ptpa_pkg::S_DONE && (!out_valid || !out_stall)) begin
      status      <= res_status;
      result_addr <= res_addr;
    end
  end

  assign in_stall = (state != ptpa_pkg::S_IDLE);

  always_comb begin
    state_next      = state;
    clr_cnt_next    = clr_cnt;
    pg_next         = pg;
    run_next        = run;
    start_next      = start;
    k_next          = k;
    f_next          = f;
    wa_next         = wa;
    res_status_next = res_status;
    res_addr_next   = res_addr;
    pr_addr = '0;
    pw_en   = 1'b0;
    pw_addr = '0;
    pw_data = '0;
    fr_addr = '0;
    fw_en   = 1'b0;
    fw_addr = '0;
    fw_data = 1'b0;
    unique case (state)
      ptpa_pkg::S_CLEAR: begin
        pw_en   = 1'b1;
        pw_addr = clr_cnt;
        fw_en   = 1'b1;
        fw_addr = clr_cnt[FB-1:0];
        clr_cnt_next = clr_cnt + 1'b1;
        if (&clr_cnt) state_next = ptpa_pkg::S_IDLE;
      end
      ptpa_pkg::S_IDLE: begin
        // free checks the page of its last byte first
        pr_addr = (func == ptpa_pkg::FUNC_FREE) ? in_last[OB +: VB] : virt_addr[OB +: VB];
        if (accept) state_next = ptpa_pkg::S_LOOK;
      end
      ptpa_pkg::S_LOOK: begin
        res_status_next = 1'b1;
        res_addr_next   = '0;
        state_next      = ptpa_pkg::S_DONE;
        case (rq_func)
          ptpa_pkg::FUNC_TRANSLATE: begin
            if (rq_va != '0 && pr_data.valid) begin
              res_status_next = 1'b0;
              res_addr_next   = AB'({pr_data.frame, rq_va[OB-1:0]});
            end
          end
          ptpa_pkg::FUNC_MAP: begin
            if (!pr_data.valid) begin
              pw_en   = 1'b1;
              pw_addr = rq_va[OB +: VB];
              pw_data = '{valid: 1'b1, frame: rq_frame};
              res_status_next = 1'b0;
            end
          end
          ptpa_pkg::FUNC_ALLOC: begin
            if (rq_need != '0 && !rq_need[VB]) begin
              pg_next    = VB'(1);
              run_next   = '0;
              state_next = ptpa_pkg::S_ARD;
            end
          end
          default: begin
            if (rq_count != '0 && !rq_last[AB] && rq_last[AB-1:0] != '0 && pr_data.valid) begin
              res_status_next = 1'b0;
              wa_next    = {1'b0, rq_va};
              state_next = ptpa_pkg::S_FRD;
            end
          end
        endcase
      end
      ptpa_pkg::S_ARD: begin
        pr_addr    = pg;
        state_next = ptpa_pkg::S_ACK;
      end
      ptpa_pkg::S_ACK: begin
        if (pr_data.valid) begin
          run_next = '0;
        end else begin
          if (run == '0) start_next = pg;
          run_next = run + 1'b1;
        end
        if (!pr_data.valid && {1'b0, run} + 1'b1 >= rq_need) begin
          k_next     = '0;
          f_next     = '0;
          state_next = ptpa_pkg::S_MRD;
        end else if (&pg) begin
          state_next = ptpa_pkg::S_DONE;
        end else begin
          pg_next    = pg + 1'b1;
          state_next = ptpa_pkg::S_ARD;
        end
      end
      ptpa_pkg::S_MRD: begin
        fr_addr = f[FB-1:0];
        // out of frames: pages mapped so far stay mapped
        state_next = f[FB] ? ptpa_pkg::S_DONE : ptpa_pkg::S_MCK;
      end
      ptpa_pkg::S_MCK: begin
        f_next     = f + 1'b1;
        state_next = ptpa_pkg::S_MRD;
        if (!fr_data) begin
          fw_en   = 1'b1;
          fw_addr = f[FB-1:0];
          fw_data = 1'b1;
          pw_en   = 1'b1;
          pw_addr = start + k;
          pw_data = '{valid: 1'b1, frame: f[FB-1:0]};
          k_next  = k + 1'b1;
          if ({1'b0, k} + 1'b1 == rq_need) begin
            res_status_next = 1'b0;
            res_addr_next   = AB'({start, {OB{1'b0}}});
            state_next      = ptpa_pkg::S_DONE;
          end
        end
      end
      ptpa_pkg::S_FRD: begin
        pr_addr    = wa[OB +: VB];
        state_next = ptpa_pkg::S_FCK;
      end
      ptpa_pkg::S_FCK: begin
        state_next = ptpa_pkg::S_DONE;
        if (wa[AB-1:0] != '0 && pr_data.valid) begin
          fw_en   = 1'b1;
          fw_addr = pr_data.frame;
          fw_data = 1'b0;
          pw_en   = 1'b1;
          pw_addr = wa[OB +: VB];
          pw_data = '{valid: 1'b0, frame: pr_data.frame};
          wa_next = wa_step;
          if (wa_step <= rq_last) state_next = ptpa_pkg::S_FRD;
        end
      end
      ptpa_pkg::S_DONE: begin
        if (!out_valid || !out_stall) state_next = ptpa_pkg::S_IDLE;
      end
      default: state_next = ptpa_pkg::S_IDLE;
    endcase
    // sweep restarts from entry zero when reset is released
    if (rst) begin
      clr_cnt_next = '0;
    end
  end

endmodule

### rtl/ptpa_checker.sv
// ----------------------------------------------------------------------------
// ptpa_checker
// Port-level checks of the page table, bound to the top level.
// ----------------------------------------------------------------------------
module ptpa_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           status,
  input logic [ptpa_pkg::ADDR_BITS-1:0] result_addr
);

  // a held result word keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_addr))
    else $error("result word changed while stalled");

  // failures carry a zero address
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> result_addr == '0)
    else $error("failed request with nonzero address");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  a_reset_out: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_stall)
    else $error("block not quiet after reset");

endmodule

bind page_table_with_page_allocator ptpa_checker u_ptpa_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status),
  .result_addr(result_addr)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives translate, map, allocate and free requests into the page table with
// random idle and stall bursts. A shadow page table predicts every response
// word, and the responses are compared in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int AB  = ptpa_pkg::ADDR_BITS;
  localparam int FRB = ptpa_pkg::FRAME_BITS;
  localparam int OB  = ptpa_pkg::OFFSET_BITS;
  localparam int VB  = ptpa_pkg::VPAGE_BITS;

  typedef struct {
    logic          status;
    logic [AB-1:0] addr;
  } resp_t;

  class page_table_scoreboard;
    bit             pg_valid [ptpa_pkg::PAGE_COUNT];
    logic [FRB-1:0] pg_frame [ptpa_pkg::PAGE_COUNT];
    bit             fr_used  [ptpa_pkg::FRAME_COUNT];
    resp_t          pending_resp[$];
    int             errors;
    int             checked;
    int             func_seen[4];
    int             fails;

    task report(string what, logic [AB-1:0] got, logic [AB-1:0] want);
      $display("mismatch %0s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    function bit walk_lookup(logic [AB-1:0] va, output logic [AB-1:0] pa);
      logic [VB-1:0] pg;
      pg = va[OB +: VB];
      pa = '0;
      if (va == 0 || !pg_valid[pg]) return 0;
      pa = AB'({pg_frame[pg], va[OB-1:0]});
      return 1;
    endfunction

    // Works out the response of one accepted request and updates the shadow.
    function void note_request(logic [1:0] fn, logic [AB-1:0] va,
                               logic [FRB-1:0] fr, logic [AB-1:0] cnt);
      resp_t         r;
      logic [AB-1:0] pa;
      logic [AB-1:0] a;
      logic [VB-1:0] pg;
      longint        need, last, off;
      int            start, run, f, k, p;
      bit            found, ok;
      r.status = 1;
      r.addr   = '0;
      func_seen[fn]++;
      case (fn)
        ptpa_pkg::FUNC_TRANSLATE: begin
          if (walk_lookup(va, pa)) begin
            r.status = 0;
            r.addr   = pa;
          end
        end
        ptpa_pkg::FUNC_MAP: begin
          pg = va[OB +: VB];
          if (!pg_valid[pg]) begin
            pg_valid[pg] = 1;
            pg_frame[pg] = fr;
            r.status     = 0;
          end
        end
        ptpa_pkg::FUNC_ALLOC: begin
          need  = (longint'(cnt) + (1 << OB) - 1) >> OB;
          found = 0;
          start = 0;
          run   = 0;
          if (need != 0 && need < ptpa_pkg::PAGE_COUNT) begin
            for (p = 1; p < ptpa_pkg::PAGE_COUNT; p++) begin
              if (pg_valid[p]) run = 0;
              else begin
                if (run == 0) start = p;
                run++;
                if (run >= need) begin
                  found = 1;
                  break;
                end
              end
            end
          end
          if (found) begin
            f  = 0;
            ok = 1;
            for (k = 0; k < need; k++) begin
              while (f < ptpa_pkg::FRAME_COUNT && fr_used[f]) f++;
              if (f >= ptpa_pkg::FRAME_COUNT) begin
                ok = 0;
                break;
              end
              fr_used[f]           = 1;
              pg_valid[start + k]  = 1;
              pg_frame[start + k]  = f[FRB-1:0];
            end
            if (ok) begin
              r.status = 0;
              r.addr   = AB'(longint'(start) << OB);
            end
          end
        end
        default: begin
          last = longint'(va) + longint'(cnt) - 1;
          if (cnt != 0 && last <= 24'hFFFFFF && walk_lookup(last[AB-1:0], pa)) begin
            r.status = 0;
            for (off = 0; off < cnt; off += (1 << OB)) begin
              a = AB'(longint'(va) + off);
              if (!walk_lookup(a, pa)) break;
              pg = a[OB +: VB];
              if (pg_frame[pg] < ptpa_pkg::FRAME_COUNT) fr_used[pg_frame[pg]] = 0;
              pg_valid[pg] = 0;
            end
          end
        end
      endcase
      if (r.status) fails++;
      pending_resp.push_back(r);
    endfunction

    task check_result(logic st, logic [AB-1:0] addr);
      resp_t w;
      checked++;
      if (pending_resp.size() == 0) begin
        report("unexpected word", addr, '0);
        return;
      end
      w = pending_resp.pop_front();
      if (st !== w.status) report("status", AB'(st), AB'(w.status));
      if (addr !== w.addr) report("result_addr", addr, w.addr);
    endtask
  endclass

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  logic [1:0]     func;
  logic [AB-1:0]  virt_addr;
  logic [FRB-1:0] frame_number;
  logic [AB-1:0]  byte_count;
  logic           out_valid;
  logic           out_stall;
  logic           status;
  logic [AB-1:0]  result_addr;

  page_table_scoreboard sb;
  bit                   idle_en;
  bit                   long_hold;
  logic [AB-1:0]        live_base[$];
  logic [AB-1:0]        live_bytes[$];

  page_table_with_page_allocator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .virt_addr(virt_addr), .frame_number(frame_number),
    .byte_count(byte_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .result_addr(result_addr)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #1000ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Response side: random stall bursts plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
        long_hold = 0;
        out_stall = 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(status, result_addr);
  end

  task send_req(logic [1:0] fn, logic [AB-1:0] va, logic [FRB-1:0] fr,
                logic [AB-1:0] cnt);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid     = 1'b1;
    func         = fn;
    virt_addr    = va;
    frame_number = fr;
    byte_count   = cnt;
    do @(posedge clk); while (in_stall);
    sb.note_request(fn, va, fr, cnt);
    // keep a list of live regions so later words can hit them
    if (fn == ptpa_pkg::FUNC_ALLOC && sb.pending_resp[$].status == 0) begin
      live_base.push_back(sb.pending_resp[$].addr);
      live_bytes.push_back(cnt);
    end
  endtask

  task drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_resp.size() != 0) @(posedge clk);
  endtask

  task random_req();
    int            sel, i;
    logic [AB-1:0] cnt;
    sel = $urandom_range(0, 99);
    if (live_base.size() > 30) sel = 60;
    if (sel < 30) begin
      if (live_base.size() > 0 && $urandom_range(0, 3) != 0) begin
        i = $urandom_range(0, live_base.size() - 1);
        send_req(ptpa_pkg::FUNC_TRANSLATE,
                 AB'(live_base[i] + $urandom_range(0, live_bytes[i] - 1)),
                 FRB'($urandom), AB'($urandom));
      end else begin
        send_req(ptpa_pkg::FUNC_TRANSLATE, AB'($urandom_range(0, 24'h7FFFF)),
                 FRB'($urandom), AB'($urandom));
      end
    end else if (sel < 42) begin
      send_req(ptpa_pkg::FUNC_MAP,
               AB'(($urandom_range(0, 127) << OB) | $urandom_range(0, 4095)),
               FRB'($urandom), AB'($urandom));
    end else if (sel < 62 && live_base.size() > 0 && sel >= 60) begin
      i = $urandom_range(0, live_base.size() - 1);
      send_req(ptpa_pkg::FUNC_FREE, live_base[i], FRB'($urandom), live_bytes[i]);
      live_base.delete(i);
      live_bytes.delete(i);
    end else if (sel < 62) begin
      send_req(ptpa_pkg::FUNC_ALLOC, AB'($urandom), FRB'($urandom),
               AB'($urandom_range(1, 6 << OB)));
    end else if (sel < 85) begin
      if (live_base.size() > 0) begin
        i = $urandom_range(0, live_base.size() - 1);
        send_req(ptpa_pkg::FUNC_FREE, live_base[i], FRB'($urandom), live_bytes[i]);
        live_base.delete(i);
        live_bytes.delete(i);
      end else begin
        send_req(ptpa_pkg::FUNC_ALLOC, AB'($urandom), FRB'($urandom),
                 AB'($urandom_range(1, 3 << OB)));
      end
    end else begin
      // noise: full-range fields, large allocations kept in check
      sel = $urandom_range(0, 3);
      cnt = AB'($urandom);
      if (sel == ptpa_pkg::FUNC_ALLOC) cnt = cnt >> $urandom_range(10, 23);
      send_req(sel[1:0], AB'($urandom), FRB'($urandom), cnt);
    end
  endtask

  initial begin
    int n;
    sb           = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    func         = ptpa_pkg::FUNC_TRANSLATE;
    virt_addr    = '0;
    frame_number = '0;
    byte_count   = '0;
    idle_en      = 1;
    long_hold    = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // frames run out partway: pages 1..1024 stay mapped, then release them
    send_req(ptpa_pkg::FUNC_ALLOC, '0, '0, 24'd2000 << OB);
    send_req(ptpa_pkg::FUNC_TRANSLATE, 24'h001234, '0, '0);
    send_req(ptpa_pkg::FUNC_FREE, 24'h001000, '0, 24'd1024 << OB);
    send_req(ptpa_pkg::FUNC_TRANSLATE, 24'h000000, '0, '0);
    send_req(ptpa_pkg::FUNC_MAP, 24'h000abc, 10'h3FF, '0);
    send_req(ptpa_pkg::FUNC_TRANSLATE, 24'h000000, '0, '0);
    send_req(ptpa_pkg::FUNC_TRANSLATE, 24'h000FFF, '0, '0);
    send_req(ptpa_pkg::FUNC_MAP, 24'h000123, 10'h155, '0);
    send_req(ptpa_pkg::FUNC_TRANSLATE, 24'h0F0FFF, '0, '0);
    send_req(ptpa_pkg::FUNC_MAP, 24'hFFF000, 10'h000, '0);
    send_req(ptpa_pkg::FUNC_TRANSLATE, 24'hFFFFFF, '0, '0);
    send_req(ptpa_pkg::FUNC_ALLOC, '0, '0, '0);
    send_req(ptpa_pkg::FUNC_ALLOC, '0, '0, 24'd1);
    send_req(ptpa_pkg::FUNC_ALLOC, '0, '0, 24'h001001);
    send_req(ptpa_pkg::FUNC_ALLOC, '0, '0, 24'd4095 << OB);
    send_req(ptpa_pkg::FUNC_ALLOC, '0, '0, 24'hFFFFFF);
    send_req(ptpa_pkg::FUNC_FREE, 24'h001000, '0, '0);
    send_req(ptpa_pkg::FUNC_FREE, 24'hFFFFFF, '0, 24'd2);
    send_req(ptpa_pkg::FUNC_FREE, 24'hFFF000, '0, 24'h001000);
    send_req(ptpa_pkg::FUNC_FREE, 24'h000000, '0, 24'h001000);
    send_req(ptpa_pkg::FUNC_FREE, 24'h001000, '0, 24'h003000);
    send_req(ptpa_pkg::FUNC_TRANSLATE, 24'h002000, '0, '0);
    send_req(ptpa_pkg::FUNC_FREE, 24'h000800, '0, 24'h004000);

    for (n = 0; n < 800; n++) begin
      if (n == 250) long_hold = 1;
      if (n == 450) drain();
      if (n == 700) idle_en = 0;
      random_req();
    end
    drain();
    repeat (50) @(posedge clk);

    $display("covered %0d translate, %0d map, %0d allocate, %0d free words",
             sb.func_seen[ptpa_pkg::FUNC_TRANSLATE], sb.func_seen[ptpa_pkg::FUNC_MAP],
             sb.func_seen[ptpa_pkg::FUNC_ALLOC], sb.func_seen[ptpa_pkg::FUNC_FREE]);
    $display("%0d responses checked, %0d of them faults or failures", sb.checked, sb.fails);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### page_table_with_page_allocator.f
rtl/ptpa_pkg.sv
rtl/page_table_with_page_allocator.sv
rtl/ptpa_checker.sv
tb/sv/testbench.sv
